// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthands for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/core/dldet_pkg.sv =====
// ----------------------------------------------------------------------------
// Deadlock detector package
// Shared widths, command codes and the control bundle sent to every cell.
// ----------------------------------------------------------------------------
`default_nettype none

package dldet_pkg;

    // Field widths fixed by the interface.
    localparam int AMT_W      = 16;
    localparam int FREE_W     = 21;
    localparam int PROC_IDX_W = 4;
    localparam int RES_IDX_W  = 3;
    localparam int NP_W       = 5;
    localparam int NR_W       = 4;
    localparam int MASK_W     = 16;
    localparam int COUNT_W    = 5;

    localparam logic [NP_W-1:0] NP_RESET = 5'd16;
    localparam logic [NR_W-1:0] NR_RESET = 4'd8;

    // Register indexes on the configuration port (taken from paddr[2]).
    localparam logic REG_NUM_PROCESSES = 1'b0;
    localparam logic REG_NUM_RESOURCES = 1'b1;

    typedef enum logic [1:0] {
        CMD_LOAD_AVAIL  = 2'd0,
        CMD_LOAD_HELD   = 2'd1,
        CMD_LOAD_WANTED = 2'd2,
        CMD_RUN         = 2'd3
    } cmd_t;

    // Broadcast control from the top level to every cell in the chain.
    typedef struct packed {
        logic                  wr_held;
        logic                  wr_wanted;
        logic                  clr_fin;
        logic [PROC_IDX_W-1:0] proc_idx;
        logic [RES_IDX_W-1:0]  res_idx;
        logic [AMT_W-1:0]      amount;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/dldet_cell.sv =====
// ----------------------------------------------------------------------------
// Deadlock detector cell
// Holds one process row (allocation, request, finished flag) and updates the
// available vector as it travels past.
// ----------------------------------------------------------------------------
`default_nettype none

module dldet_cell
    import dldet_pkg::*;
#(
    parameter int MAX_RESOURCES = 8,
    parameter int CNT_W         = 5,
    parameter int INDEX         = 0
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire cell_ctrl_t                           ctrl,
    input  wire logic                                 active,
    input  wire logic [MAX_RESOURCES-1:0]             col_en,
    input  wire logic                                 in_valid,
    input  wire logic [MAX_RESOURCES-1:0][FREE_W-1:0] in_free,
    input  wire logic                                 in_rel,
    input  wire logic [CNT_W-1:0]                     in_cnt,
    output logic                                      out_valid,
    output logic [MAX_RESOURCES-1:0][FREE_W-1:0]      out_free,
    output logic                                      out_rel,
    output logic [CNT_W-1:0]                          out_cnt,
    output logic                                      finished
);

    localparam logic [FREE_W-1:0] FREE_MAX = '1;

    logic [AMT_W-1:0]  held_reg   [MAX_RESOURCES];
    logic [AMT_W-1:0]  held_next  [MAX_RESOURCES];
    logic [AMT_W-1:0]  wanted_reg [MAX_RESOURCES];
    logic [AMT_W-1:0]  wanted_next[MAX_RESOURCES];
    logic              fin_reg;
    logic              fin_next;
    logic              valid_reg;
    logic              rel_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [MAX_RESOURCES-1:0][FREE_W-1:0] free_reg;
    logic [MAX_RESOURCES-1:0][FREE_W-1:0] free_next;

    logic row_hit;
    logic fits;
    logic take;
    logic unfin;

    assign row_hit = (int'(ctrl.proc_idx) == INDEX);

    // The process qualifies when every request in use is covered.
    always_comb
    begin
        fits = 1'b1;
        for (int k = 0; k < MAX_RESOURCES; k++)
        begin
            if (col_en[k] && (FREE_W'(wanted_reg[k]) > in_free[k]))
            begin
                fits = 1'b0;
            end
        end
    end

    assign take  = in_valid & active & ~fin_reg & fits;
    assign unfin = active & ~fin_reg & ~fits;

    always_comb
    begin
        logic [FREE_W:0] sum;
        for (int k = 0; k < MAX_RESOURCES; k++)
        begin
            sum = {1'b0, in_free[k]} + (FREE_W + 1)'(held_reg[k]);
            if (take && col_en[k])
            begin
                free_next[k] = sum[FREE_W] ? FREE_MAX : sum[FREE_W-1:0];
            end
            else
            begin
                free_next[k] = in_free[k];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < MAX_RESOURCES; k++)
        begin
            held_next[k]   = held_reg[k];
            wanted_next[k] = wanted_reg[k];
            if (ctrl.wr_held && row_hit && (int'(ctrl.res_idx) == k))
            begin
                held_next[k] = ctrl.amount;
            end
            else if (take && col_en[k])
            begin
                held_next[k] = '0;
            end
            if (ctrl.wr_wanted && row_hit && (int'(ctrl.res_idx) == k))
            begin
                wanted_next[k] = ctrl.amount;
            end
            else if (take && col_en[k] && (held_reg[k] != '0))
            begin
                wanted_next[k] = '0;
            end
        end
    end

    always_comb
    begin
        fin_next = fin_reg;
        if (ctrl.clr_fin)
        begin
            fin_next = 1'b0;
        end
        else if (take)
        begin
            fin_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_RESOURCES; k++)
            begin
                held_reg[k]   <= '0;
                wanted_reg[k] <= '0;
            end
            fin_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            held_reg   <= held_next;
            wanted_reg <= wanted_next;
            fin_reg    <= fin_next;
            valid_reg  <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        free_reg <= free_next;
        rel_reg  <= in_rel | take;
        cnt_reg  <= in_cnt + CNT_W'(unfin);
    end

    assign out_valid = valid_reg;
    assign out_free  = free_reg;
    assign out_rel   = rel_reg;
    assign out_cnt   = cnt_reg;
    assign finished  = fin_reg;

endmodule

`default_nettype wire

// ===== rtl/core/deadlock_detector_core.sv =====
// ----------------------------------------------------------------------------
// Deadlock detector core
// Stores the available vector and the allocation and request matrices and
// runs deadlock detection over them in a chain of per-process cells.
// ----------------------------------------------------------------------------
// A load transaction (available, allocation or request entry) is taken only
// while the block is idle, and back-to-back loads are then accepted every
// cycle. A run transaction clears the finished flags and then sends the
// available vector down a chain of MAX_PROCESSES cells, one cell per cycle;
// each cell holds one process row, and a cell whose request row fits the
// passing vector adds its allocation into it, clears that allocation and the
// request entries of the columns it held, and marks itself finished. A pass
// that released at least one process is followed at once by another pass, so
// a run makes P passes, where P lies between 1 and num_processes + 1. The
// final pass, which changes nothing, also counts the unfinished processes.
// The result transaction (mask and count) sits in an output register, so
// loads are accepted while it waits; a new run is only started from idle and
// its result waits in the report state until the output register is free.
// Configuration writes go through the APB-style port and must happen while
// the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module deadlock_detector_core
    import dldet_pkg::*;
#(
    parameter int MAX_PROCESSES = 16,
    parameter int MAX_RESOURCES = 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Input channel.
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [1:0]            command,
    input  wire logic [PROC_IDX_W-1:0] process_index,
    input  wire logic [RES_IDX_W-1:0]  resource_index,
    input  wire logic [AMT_W-1:0]      amount,
    // Result channel.
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [MASK_W-1:0]          deadlocked_mask,
    output logic [COUNT_W-1:0]         deadlocked_count,
    // Configuration port.
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int CNT_W  = $clog2(MAX_PROCESSES + 1);
    localparam int MASK_N = (MAX_PROCESSES < MASK_W) ? MAX_PROCESSES : MASK_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_START  = 4'b0010,
        ST_SWEEP  = 4'b0100,
        ST_REPORT = 4'b1000
    } state_t;

    typedef logic [MAX_RESOURCES-1:0][FREE_W-1:0] free_vec_t;

    state_t            state_reg;
    state_t            state_next;
    free_vec_t         free_reg;
    free_vec_t         free_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [NP_W-1:0]   np_reg;
    logic [NR_W-1:0]   nr_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [MASK_W-1:0] mask_reg;
    logic [MASK_W-1:0] mask_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    cmd_t              cmd;
    logic              in_fire;
    logic              cfg_wr;
    cell_ctrl_t        ctrl;
    logic [MAX_PROCESSES-1:0] active;
    logic [MAX_PROCESSES-1:0] finished;
    logic [MAX_RESOURCES-1:0] col_en;
    logic [MASK_W-1:0]        mask_now;
    logic                     head_valid;
    free_vec_t                head_free;

    // Wavefront links: index 0 is the head fed by the control, the last one
    // is the output of the final cell.
    logic [MAX_PROCESSES:0] wf_valid;
    logic [MAX_PROCESSES:0] wf_rel;
    free_vec_t              wf_free [MAX_PROCESSES+1];
    logic [CNT_W-1:0]       wf_cnt  [MAX_PROCESSES+1];

    assign wf_valid[0] = head_valid;
    assign wf_free[0]  = head_free;
    assign wf_rel[0]   = 1'b0;
    assign wf_cnt[0]   = '0;

    assign cmd      = cmd_t'(command);
    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid & in_ready;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            np_reg <= NP_RESET;
            nr_reg <= NR_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_NUM_PROCESSES: np_reg <= pwdata[NP_W-1:0];
                REG_NUM_RESOURCES: nr_reg <= pwdata[NR_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_NUM_PROCESSES: prdata = 32'(np_reg);
            REG_NUM_RESOURCES: prdata = 32'(nr_reg);
            default:           prdata = '0;
        endcase
    end

    // A counter above its maximum simply enables every cell or column.
    always_comb
    begin
        for (int i = 0; i < MAX_PROCESSES; i++)
        begin
            active[i] = (int'(np_reg) > i);
        end
        for (int k = 0; k < MAX_RESOURCES; k++)
        begin
            col_en[k] = (int'(nr_reg) > k);
        end
    end

    // ------------------------------------------------------------------
    // Broadcast control for loads and the start of a run.
    // ------------------------------------------------------------------
    always_comb
    begin
        ctrl.wr_held   = in_fire && (cmd == CMD_LOAD_HELD);
        ctrl.wr_wanted = in_fire && (cmd == CMD_LOAD_WANTED);
        ctrl.clr_fin   = in_fire && (cmd == CMD_RUN);
        ctrl.proc_idx  = process_index;
        ctrl.res_idx   = resource_index;
        ctrl.amount    = amount;
    end

    // ------------------------------------------------------------------
    // Chain of process cells.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < MAX_PROCESSES; i++)
    begin : g_cell
        dldet_cell #(
            .MAX_RESOURCES (MAX_RESOURCES),
            .CNT_W         (CNT_W),
            .INDEX         (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .active    (active[i]),
            .col_en    (col_en),
            .in_valid  (wf_valid[i]),
            .in_free   (wf_free[i]),
            .in_rel    (wf_rel[i]),
            .in_cnt    (wf_cnt[i]),
            .out_valid (wf_valid[i+1]),
            .out_free  (wf_free[i+1]),
            .out_rel   (wf_rel[i+1]),
            .out_cnt   (wf_cnt[i+1]),
            .finished  (finished[i])
        );
    end

    // The mask only reports the first sixteen processes.
    always_comb
    begin
        mask_now = '0;
        for (int i = 0; i < MASK_N; i++)
        begin
            mask_now[i] = active[i] & ~finished[i];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        free_next      = free_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        mask_next      = mask_reg;
        count_next     = count_reg;
        head_valid     = 1'b0;
        head_free      = free_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (cmd)
                        CMD_LOAD_AVAIL:
                        begin
                            for (int k = 0; k < MAX_RESOURCES; k++)
                            begin
                                if (int'(resource_index) == k)
                                begin
                                    free_next[k] = FREE_W'(amount);
                                end
                            end
                        end
                        CMD_RUN:
                        begin
                            state_next = ST_START;
                        end
                        default:
                        begin
                            // Matrix loads are written inside the cells.
                        end
                    endcase
                end
            end
            ST_START:
            begin
                // Finished flags were cleared when the run was accepted.
                head_valid = 1'b1;
                state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                if (wf_valid[MAX_PROCESSES])
                begin
                    free_next = wf_free[MAX_PROCESSES];
                    if (wf_rel[MAX_PROCESSES])
                    begin
                        head_valid = 1'b1;
                        head_free  = wf_free[MAX_PROCESSES];
                    end
                    else
                    begin
                        cnt_next   = wf_cnt[MAX_PROCESSES];
                        state_next = ST_REPORT;
                    end
                end
            end
            ST_REPORT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    mask_next      = mask_now;
                    count_next     = COUNT_W'(cnt_reg);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            free_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            free_reg      <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        mask_reg  <= mask_next;
        count_reg <= count_next;
    end

    assign out_valid        = out_valid_reg;
    assign deadlocked_mask  = mask_reg;
    assign deadlocked_count = count_reg;

endmodule

`default_nettype wire

// ===== rtl/core/dldet_checker.sv =====
// ----------------------------------------------------------------------------
// Deadlock detector checker
// Port-level properties of the deadlock detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dldet_checker
    import dldet_pkg::*;
#(
    parameter int MAX_PROCESSES = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic [1:0]         command,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic [MASK_W-1:0]  deadlocked_mask,
    input  wire logic [COUNT_W-1:0] deadlocked_count
);

    // A waiting result transaction must not change.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(deadlocked_mask) && $stable(deadlocked_count))

    // When every process fits in the mask, the count agrees with it.
    `ASSERT_SAME(a_count_match, clk, rst_n, out_valid, (MAX_PROCESSES > MASK_W) || ($countones(deadlocked_mask) == int'(deadlocked_count)))

    // A run keeps the block busy for at least the following cycle.
    `ASSERT_NEXT(a_run_busy, clk, rst_n, in_valid && in_ready && (command == CMD_RUN), !in_ready)

    // A fresh result only appears at the end of a run.
    `ASSERT_SAME(a_result_after_run, clk, rst_n, $rose(out_valid), !$past(in_ready))

endmodule

bind deadlock_detector_core dldet_checker #(.MAX_PROCESSES(MAX_PROCESSES)) u_dldet_checker (.*);

`default_nettype wire

// ===== verif/tb_deadlock_detector_core.sv =====
// ============================================================================
// Deadlock detector core testbench
// Loads the available vector and the allocation and request matrices, starts
// detection runs and checks every reported mask and count against a
// cycle-free prediction of the detection algorithm, under several process and
// resource counts and with random idling on both channels.
// ============================================================================
`default_nettype none

module tb_deadlock_detector_core
    import dldet_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 20;
    localparam int MAX_PROCESSES = 16;
    localparam int MAX_RESOURCES = 8;

    // A run makes at most num_processes + 1 passes over a chain of
    // MAX_PROCESSES cells, plus the start and report states.
    localparam int RUN_LATENCY  = 2 + (MAX_PROCESSES + 1) * MAX_PROCESSES;
    // Loads are taken while the block is idle; a short settle covers them.
    localparam int LOAD_SETTLE  = 4;
    // Cycles without any transaction before the run is declared hung.
    localparam int STALL_LIMIT  = 16 * RUN_LATENCY;
    localparam int PHASE_ITEMS  = 205;
    localparam int NUM_PHASES   = 8;

    localparam logic [FREE_W-1:0] FREE_LIMIT = {FREE_W{1'b1}};

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct {
        cmd_t                  cmd;
        logic [PROC_IDX_W-1:0] proc_idx;
        logic [RES_IDX_W-1:0]  res_idx;
        logic [AMT_W-1:0]      amount;
    } detector_txn_t;

    typedef struct {
        logic [MASK_W-1:0]  mask;
        logic [COUNT_W-1:0] count;
    } deadlock_report_t;

    // Each phase after the directed part runs with its own counts and idling.
    // The set includes counts above the storage size, zero processes and
    // zero resource types.
    localparam int PHASE_NP[NUM_PHASES] = '{4, 16, 1, 31, 0, 7, 12, 16};
    localparam int PHASE_NR[NUM_PHASES] = '{3, 8, 1, 15, 5, 0, 6, 8};
    localparam idle_mode_t PHASE_IDLE[NUM_PHASES] = '{
        IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
        IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH
    };

    // ------------------------------------------------------------------------
    // Clock, reset and DUT signals. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  in_valid       = 1'b0;
    logic                  in_ready;
    logic [1:0]            command        = CMD_LOAD_AVAIL;
    logic [PROC_IDX_W-1:0] process_index  = '0;
    logic [RES_IDX_W-1:0]  resource_index = '0;
    logic [AMT_W-1:0]      amount         = '0;
    logic                  out_valid;
    logic                  out_ready      = 1'b0;
    logic [MASK_W-1:0]     deadlocked_mask;
    logic [COUNT_W-1:0]    deadlocked_count;
    logic                  psel           = 1'b0;
    logic                  penable        = 1'b0;
    logic                  pwrite         = 1'b0;
    logic [2:0]            paddr          = '0;
    logic [31:0]           pwdata         = '0;
    logic [31:0]           prdata;
    logic                  pready;

    always #(CLK_PERIOD / 2) clk = ~clk;

    deadlock_detector_core #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .MAX_RESOURCES (MAX_RESOURCES)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .command          (command),
        .process_index    (process_index),
        .resource_index   (resource_index),
        .amount           (amount),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .deadlocked_mask  (deadlocked_mask),
        .deadlocked_count (deadlocked_count),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // ------------------------------------------------------------------------
    // Predicted state of the block: the available vector, both matrices and
    // the two count registers. It advances once per accepted transaction.
    // ------------------------------------------------------------------------
    logic [FREE_W-1:0] free_units   [MAX_RESOURCES];
    logic [AMT_W-1:0]  held_units   [MAX_PROCESSES][MAX_RESOURCES];
    logic [AMT_W-1:0]  wanted_units [MAX_PROCESSES][MAX_RESOURCES];
    logic [NP_W-1:0]   cfg_processes = NP_RESET;
    logic [NR_W-1:0]   cfg_resources = NR_RESET;

    detector_txn_t    pending_txns[$];
    deadlock_report_t expected_reports[$];
    detector_txn_t    presented_txn;

    int mismatches    = 0;
    int quiet_cycles  = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // The three load commands come first, so an index up to 2 picks a load.
    cmd_t all_cmds[4] = '{CMD_LOAD_AVAIL, CMD_LOAD_HELD, CMD_LOAD_WANTED, CMD_RUN};

    initial begin
        foreach (free_units[k]) free_units[k] = '0;
        foreach (held_units[p, k]) held_units[p][k] = '0;
        foreach (wanted_units[p, k]) wanted_units[p][k] = '0;
    end

    // Applies one accepted transaction to the predicted state. A run walks
    // the processes from index 0, releases the first unfinished one whose
    // request row fits the available vector, and restarts the scan after each
    // release. Whatever is left unfinished is reported as deadlocked.
    function automatic void update_and_detect(input detector_txn_t t);
        int unsigned      np;
        int unsigned      nr;
        int unsigned      p;
        int unsigned      sum;
        logic             fits;
        logic [MAX_PROCESSES-1:0] done;
        deadlock_report_t report;
        case (t.cmd)
            CMD_LOAD_AVAIL:  free_units[t.res_idx] = FREE_W'(t.amount);
            CMD_LOAD_HELD:   held_units[t.proc_idx][t.res_idx] = t.amount;
            CMD_LOAD_WANTED: wanted_units[t.proc_idx][t.res_idx] = t.amount;
            default:
            begin
                // Counts above the storage size are clamped to it.
                np = (cfg_processes > MAX_PROCESSES) ? MAX_PROCESSES : cfg_processes;
                nr = (cfg_resources > MAX_RESOURCES) ? MAX_RESOURCES : cfg_resources;
                done = '0;
                p = 0;
                while (p < np) begin
                    fits = !done[p];
                    for (int k = 0; k < nr; k++) begin
                        if (wanted_units[p][k] > free_units[k]) begin
                            fits = 1'b0;
                        end
                    end
                    if (fits) begin
                        // Only columns the process actually holds are
                        // returned, and only those request entries are cleared.
                        for (int k = 0; k < nr; k++) begin
                            if (held_units[p][k] != '0) begin
                                sum = free_units[k] + held_units[p][k];
                                free_units[k] = (sum > FREE_LIMIT) ? FREE_LIMIT
                                                                   : FREE_W'(sum);
                                held_units[p][k]   = '0;
                                wanted_units[p][k] = '0;
                            end
                        end
                        done[p] = 1'b1;
                        p = 0;
                    end
                    else begin
                        p++;
                    end
                end
                report.mask  = '0;
                report.count = '0;
                for (int q = 0; q < np; q++) begin
                    if (!done[q]) begin
                        report.mask[q] = 1'b1;
                        report.count++;
                    end
                end
                expected_reports.push_back(report);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Driver. A transaction stays on the input channel until accepted; the
    // next one is either presented in the same step or, with the sender idle
    // probability, held back with in_valid low.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else begin
            if (in_valid && in_ready) begin
                update_and_detect(presented_txn);
            end
            if (!in_valid || in_ready) begin
                if (pending_txns.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    presented_txn  = pending_txns.pop_front();
                    in_valid       <= 1'b1;
                    command        <= presented_txn.cmd;
                    process_index  <= presented_txn.proc_idx;
                    resource_index <= presented_txn.res_idx;
                    amount         <= presented_txn.amount;
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Each accepted report is compared with the oldest prediction;
    // out_ready is redrawn every cycle to produce receiver stalls.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        deadlock_report_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected report: expected none, actual mask %h count %0d",
                             $time, deadlocked_mask, deadlocked_count);
                    mismatches++;
                end
                else begin
                    want = expected_reports.pop_front();
                    if (deadlocked_mask !== want.mask) begin
                        $display("%0t: deadlocked_mask mismatch: expected %h, actual %h",
                                 $time, want.mask, deadlocked_mask);
                        mismatches++;
                    end
                    if (deadlocked_count !== want.count) begin
                        $display("%0t: deadlocked_count mismatch: expected %0d, actual %0d",
                                 $time, want.count, deadlocked_count);
                        mismatches++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog. Any transaction on either channel restarts the count; a long
    // silence means the block has hung.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge clk);
        end
        $display("tb_deadlock_detector_core: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic void push_txn(input cmd_t cmd, input int unsigned p,
                                     input int unsigned r, input int unsigned amt);
        detector_txn_t t;
        t.cmd      = cmd;
        t.proc_idx = PROC_IDX_W'(p);
        t.res_idx  = RES_IDX_W'(r);
        t.amount   = AMT_W'(amt);
        pending_txns.push_back(t);
    endfunction

    // Mostly small counts, so request rows and the available vector are close
    // and both deadlocks and releases happen; now and then the extremes.
    function automatic int unsigned pick_amount();
        int unsigned roll;
        roll = $urandom_range(19);
        case (roll)
            0:       return 32'hFFFF;
            1:       return $urandom_range(16'hFFFF);
            2:       return 0;
            default: return $urandom_range(6);
        endcase
    endfunction

    // Indices mostly fall inside the counts in use; the rest may land anywhere
    // in storage, also in unused rows and columns.
    function automatic int unsigned pick_index(input int unsigned in_use,
                                               input int unsigned storage);
        int unsigned lim;
        lim = (in_use > storage) ? storage : in_use;
        if (lim == 0 || $urandom_range(99) < 15) begin
            return $urandom_range(storage - 1);
        end
        return $urandom_range(lim - 1);
    endfunction

    // Fills the queue with roughly the given number of transactions. Most are
    // short load bursts closed by a run; a few pile full allocation columns
    // onto one resource twice in a row to drive the available count towards
    // saturation; the rest is unstructured noise.
    function automatic void queue_random_phase(input int target);
        int          produced;
        int          burst;
        int unsigned roll;
        int unsigned col;
        produced = 0;
        while (produced < target) begin
            roll = $urandom_range(99);
            if (roll < 80) begin
                burst = $urandom_range(10, 1);
                for (int i = 0; i < burst; i++) begin
                    push_txn(all_cmds[$urandom_range(2)],
                             pick_index(cfg_processes, MAX_PROCESSES),
                             pick_index(cfg_resources, MAX_RESOURCES),
                             pick_amount());
                end
                push_txn(CMD_RUN, $urandom_range(15), $urandom_range(7), $urandom);
                produced += burst + 1;
            end
            else if (roll < 85) begin
                col = pick_index(cfg_resources, MAX_RESOURCES);
                repeat (2) begin
                    for (int p = 0; p < MAX_PROCESSES; p++) begin
                        push_txn(CMD_LOAD_HELD, p, col, 32'hFFFF);
                    end
                    push_txn(CMD_RUN, 0, 0, 0);
                end
                produced += 2 * (MAX_PROCESSES + 1);
            end
            else begin
                push_txn(all_cmds[$urandom_range(3)], $urandom_range(15),
                         $urandom_range(7), $urandom);
                produced++;
            end
        end
    endfunction

    // Waits until every queued transaction is accepted and every predicted
    // report has arrived, then lets any trailing work settle.
    task automatic wait_drained(input int settle);
        while (pending_txns.size() != 0 || in_valid || expected_reports.size() != 0) begin
            @(posedge clk);
        end
        repeat (settle) @(posedge clk);
    endtask

    // One APB transfer: setup cycle, access cycle, and the register is
    // written (or prdata taken) at the edge that closes the access cycle.
    task automatic apb_transfer(input logic wr, input logic [2:0] addr,
                                input logic [31:0] data, output logic [31:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Writes a count register, reads it back and updates the prediction.
    task automatic set_register(input logic reg_idx, input logic [31:0] value);
        logic [2:0]  addr;
        logic [31:0] rdata;
        logic [31:0] stored;
        addr = {reg_idx, 2'b00};
        if (reg_idx == REG_NUM_PROCESSES) begin
            stored = {{(32 - NP_W){1'b0}}, value[NP_W-1:0]};
        end
        else begin
            stored = {{(32 - NR_W){1'b0}}, value[NR_W-1:0]};
        end
        apb_transfer(1'b1, addr, value, rdata);
        apb_transfer(1'b0, addr, '0, rdata);
        if (rdata !== stored) begin
            $display("%0t: register %0d readback mismatch: expected %h, actual %h",
                     $time, reg_idx, stored, rdata);
            mismatches++;
        end
        if (reg_idx == REG_NUM_PROCESSES) begin
            cfg_processes = value[NP_W-1:0];
        end
        else begin
            cfg_resources = value[NR_W-1:0];
        end
    endtask

    task automatic set_idle_mode(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER:
            begin
                send_idle_pct  = 77;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 77;
            end
            IDLE_BOTH:
            begin
                send_idle_pct  = 18;
                recv_stall_pct = 18;
            end
            default:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, with the reset counts of 16 processes and 8 types.
        // An empty system: nothing is held or wanted, so nobody is stuck.
        push_txn(CMD_RUN, 0, 0, 0);
        // A classic two-process cycle: each holds what the other wants and
        // nothing is available.
        push_txn(CMD_LOAD_HELD, 0, 1, 1);
        push_txn(CMD_LOAD_WANTED, 0, 0, 1);
        push_txn(CMD_LOAD_HELD, 1, 0, 1);
        push_txn(CMD_LOAD_WANTED, 1, 1, 1);
        push_txn(CMD_RUN, 0, 0, 0);
        // One free unit breaks the cycle; the row index of an available load
        // is ignored.
        push_txn(CMD_LOAD_AVAIL, 9, 1, 1);
        push_txn(CMD_RUN, 0, 0, 0);
        // Full-scale request just one above what is available.
        push_txn(CMD_LOAD_WANTED, 15, 7, 32'hFFFF);
        push_txn(CMD_LOAD_AVAIL, 0, 7, 32'hFFFE);
        push_txn(CMD_RUN, 0, 0, 0);
        // Request exactly equal to what is available, releasing a full-scale
        // allocation.
        push_txn(CMD_LOAD_AVAIL, 0, 7, 32'hFFFF);
        push_txn(CMD_LOAD_HELD, 15, 3, 32'hFFFF);
        push_txn(CMD_RUN, 0, 0, 0);
        // A lone blocked process in the middle of the range.
        push_txn(CMD_LOAD_HELD, 10, 6, 32'hFFFF);
        push_txn(CMD_LOAD_WANTED, 10, 2, 1);
        push_txn(CMD_LOAD_AVAIL, 0, 2, 0);
        push_txn(CMD_RUN, 0, 0, 0);
        wait_drained(LOAD_SETTLE);

        // Random phases, each with its own counts and idling.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_register(REG_NUM_PROCESSES, PHASE_NP[ph]);
            set_register(REG_NUM_RESOURCES, PHASE_NR[ph]);
            set_idle_mode(PHASE_IDLE[ph]);
            queue_random_phase(PHASE_ITEMS);
            wait_drained(LOAD_SETTLE);
        end

        // Allow a full run's worth of cycles for any stray report to show up.
        repeat (RUN_LATENCY) @(posedge clk);
        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("tb_deadlock_detector_core: PASS");
        end
        else begin
            $display("tb_deadlock_detector_core: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
